[src/urod_pkg.sv]
`timescale 1ns / 1ps

package urod_pkg;

   // field widths
   localparam int TRIG_W   = 10;
   localparam int TMO_W    = 16;
   localparam int INTV_W   = 16;
   localparam int DIST_W   = 11;
   localparam int COUNT_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // microsecond ticks per millisecond
   localparam int TICKS_PER_MS = 1000;
   localparam int TICK_W       = $clog2(TICKS_PER_MS + 1);

   localparam logic [COUNT_W-1:0] PRE_LOW_TICKS = COUNT_W'(2);
   localparam int                 US_PER_CM     = 58;

   // pulse / 58 as (pulse * RECIP) >> SHIFT, exact for any 16 bit pulse
   localparam int                 DIV_SHIFT = 21;
   localparam logic [COUNT_W-1:0] DIV_RECIP =
      COUNT_W'(((1 << DIV_SHIFT) + US_PER_CM - 1) / US_PER_CM);
   localparam int                 PROD_W = 2 * COUNT_W;

   // register reset values
   localparam logic [TRIG_W-1:0] TRIG_RESET  = TRIG_W'(10);
   localparam logic [TMO_W-1:0]  TMO_RESET   = TMO_W'(30000);
   localparam logic [INTV_W-1:0] INTV_RESET  = INTV_W'(100);
   localparam logic [DIST_W-1:0] STOP_RESET  = DIST_W'(20);
   localparam logic [DIST_W-1:0] CLEAR_RESET = DIST_W'(30);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_PULSE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTV   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DIST     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_DIST    = CSR_IDX_W'(4);

   typedef enum logic [2:0] {
      PH_PRE_LOW   = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_ECHO = 3'd2,
      PH_ECHO_HIGH = 3'd3,
      PH_IDLE      = 3'd4
   } phase_type;

   typedef struct packed {
      logic              trigger_level;
      logic              signal_level;
      logic              reading_valid;
      logic              obstacle;
      logic [DIST_W-1:0] range_cm;
      logic              measure_done;
   } rsp_type;

endpackage

[src/ultrasonic_range_obstacle_detector_core.sv]
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// req      in         req_valid/stall    echo_level, external_alarm
// rsp      out        rsp_valid/stall    trigger, signal, valid, obstacle, distance, done
// csr      in         csr_we             csr_index, csr_wdata
//
// One transaction per cycle while req_stall is low: each tick is handled in one pass from the sequencer
// state to the result register, with one constant multiply for the distance.
// A two-entry output (result register plus skid) keeps req flowing while a
// result waits; req_stall rises only once the skid entry is occupied.
// Synchronous active-high reset; a measurement starts on the first tick after it.

module ultrasonic_range_obstacle_detector_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_echo_level,
   input  logic                             req_external_alarm,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_trigger_level,
   output logic                             rsp_signal_level,
   output logic                             rsp_reading_valid,
   output logic                             rsp_obstacle,
   output logic [urod_pkg::DIST_W-1:0]      rsp_range_cm,
   output logic                             rsp_measure_done,
   input  logic                             csr_we,
   input  logic [urod_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [urod_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import urod_pkg::*;

   // configuration
   logic [TRIG_W-1:0] trig_len_ff;
   logic [TMO_W-1:0]  timeout_ff;
   logic [INTV_W-1:0] interval_ff;
   logic [DIST_W-1:0] stop_ff;
   logic [DIST_W-1:0] clear_ff;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TICK_W-1:0]  prescale_ff, prescale_in;
   logic [INTV_W-1:0]  ms_ff, ms_in;
   logic               valid_ff, valid_in;
   logic               obst_ff, obst_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;

   // output buffer
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;
   rsp_type result;

   logic               accept;
   logic               out_take;
   logic               start;
   phase_type          cur_phase;
   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] count_inc;
   logic               tmo_hit;
   logic               trig;
   logic               ok;
   logic               fail;
   logic [PROD_W-1:0]  prod;
   logic [DIST_W-1:0]  quot;
   logic [DIST_W-1:0]  dist_new;
   logic [TICK_W:0]    pres_inc;
   logic [TICK_W-1:0]  pres_base;
   logic [INTV_W-1:0]  ms_base;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign out_take  = out_valid_ff & ~rsp_stall;

   // a new measurement begins from idle once the interval has run out
   assign start     = (phase_ff == PH_IDLE) && (ms_ff >= interval_ff);
   assign cur_phase = start ? PH_PRE_LOW : phase_ff;
   assign cur_count = start ? '0 : count_ff;
   assign count_inc = cur_count + COUNT_W'(1);
   assign tmo_hit   = cur_count >= timeout_ff;

   // next phase and count
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      unique case (cur_phase)
         PH_PRE_LOW: begin
            if (count_inc >= PRE_LOW_TICKS) begin
               phase_in = PH_TRIG_HIGH;
               count_in = '0;
            end else begin
               phase_in = PH_PRE_LOW;
               count_in = count_inc;
            end
         end
         PH_TRIG_HIGH: begin
            // zero length still gives one high tick
            if (count_inc >= COUNT_W'(trig_len_ff)) begin
               phase_in = PH_WAIT_ECHO;
               count_in = '0;
            end else begin
               phase_in = PH_TRIG_HIGH;
               count_in = count_inc;
            end
         end
         PH_WAIT_ECHO: begin
            if (req_echo_level) begin
               if (timeout_ff == '0) begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end else begin
                  phase_in = PH_ECHO_HIGH;
                  count_in = COUNT_W'(1);
               end
            end else if (tmo_hit) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               phase_in = PH_WAIT_ECHO;
               count_in = count_inc;
            end
         end
         PH_ECHO_HIGH: begin
            if (!req_echo_level || tmo_hit) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               phase_in = PH_ECHO_HIGH;
               count_in = count_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = count_ff;
         end
      endcase
   end

   // outputs and measurement flags
   always_comb begin
      trig = (cur_phase == PH_TRIG_HIGH);
      ok   = (cur_phase == PH_ECHO_HIGH) && !req_echo_level;
      fail = ((cur_phase == PH_WAIT_ECHO) &&
              ((req_echo_level && (timeout_ff == '0)) || (!req_echo_level && tmo_hit))) ||
             ((cur_phase == PH_ECHO_HIGH) && req_echo_level && tmo_hit);

      prod     = PROD_W'(cur_count) * PROD_W'(DIV_RECIP);
      quot     = prod[DIV_SHIFT +: DIST_W];
      dist_new = (quot == '0) ? DIST_W'(1) : quot;

      valid_in = valid_ff;
      obst_in  = obst_ff;
      dist_in  = dist_ff;
      if (fail) begin
         valid_in = 1'b0;
         obst_in  = 1'b0;
      end else if (ok) begin
         valid_in = 1'b1;
         dist_in  = dist_new;
         if (dist_new <= stop_ff) begin
            obst_in = 1'b1;
         end else if (dist_new >= clear_ff) begin
            obst_in = 1'b0;
         end
      end

      result.trigger_level = trig;
      result.signal_level  = obst_in | req_external_alarm;
      result.reading_valid = valid_in;
      result.obstacle      = obst_in;
      result.range_cm      = dist_in;
      result.measure_done  = ok | fail;
   end

   // millisecond timer, restarted with each measurement, saturating
   always_comb begin
      pres_base   = start ? '0 : prescale_ff;
      ms_base     = start ? '0 : ms_ff;
      pres_inc    = {1'b0, pres_base} + (TICK_W + 1)'(1);
      prescale_in = pres_inc[TICK_W-1:0];
      ms_in       = ms_base;
      if (pres_inc >= (TICK_W + 1)'(TICKS_PER_MS)) begin
         prescale_in = '0;
         if (ms_base != '1) begin
            ms_in = ms_base + INTV_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_len_ff <= TRIG_RESET;
         timeout_ff  <= TMO_RESET;
         interval_ff <= INTV_RESET;
         stop_ff     <= STOP_RESET;
         clear_ff    <= CLEAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_PULSE: trig_len_ff <= csr_wdata[TRIG_W-1:0];
            CSR_ECHO_TIMEOUT:  timeout_ff  <= csr_wdata[TMO_W-1:0];
            CSR_UPDATE_INTV:   interval_ff <= csr_wdata[INTV_W-1:0];
            CSR_STOP_DIST:     stop_ff     <= csr_wdata[DIST_W-1:0];
            CSR_CLEAR_DIST:    clear_ff    <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PRE_LOW;
         count_ff    <= '0;
         prescale_ff <= '0;
         ms_ff       <= '0;
         valid_ff    <= 1'b0;
         obst_ff     <= 1'b0;
         dist_ff     <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         prescale_ff <= prescale_in;
         ms_ff       <= ms_in;
         valid_ff    <= valid_in;
         obst_ff     <= obst_in;
         dist_ff     <= dist_in;
      end
   end

   // result register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (out_valid_ff && !out_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_level = out_ff.trigger_level;
   assign rsp_signal_level  = out_ff.signal_level;
   assign rsp_reading_valid = out_ff.reading_valid;
   assign rsp_obstacle      = out_ff.obstacle;
   assign rsp_range_cm      = out_ff.range_cm;
   assign rsp_measure_done  = out_ff.measure_done;

endmodule
